/* design/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Shared types, constants and helpers for the beeper pattern sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package bps_pkg;

    typedef enum logic [1:0] {
        MODE_TICK     = 2'd0,
        MODE_START    = 2'd1,
        MODE_SET_FREQ = 2'd2,
        MODE_UNUSED   = 2'd3
    } mode_t;

    localparam logic [7:0]  TONE_NONE  = 8'd0;
    localparam logic [7:0]  TONE_SHORT = 8'd1;
    localparam logic [7:0]  TONE_DOUBLE = 8'd2;
    localparam logic [7:0]  TONE_TRIPLE = 8'd3;
    localparam logic [7:0]  TONE_SWEEP = 8'd4;

    localparam logic [7:0]  LEN_SHORT = 8'd30;
    localparam logic [7:0]  LEN_LONG  = 8'd50;
    localparam logic [7:0]  LEN_SWEEP = 8'd40;

    localparam logic [15:0] FREQ_BASE = 16'd1000;
    localparam logic [15:0] FREQ_STEP = 16'd25;

    localparam logic [3:0]  LAST_STAGE_DOUBLE = 4'd3;
    localparam logic [3:0]  LAST_STAGE_TRIPLE = 4'd4;
    localparam logic [3:0]  LAST_STAGE_SWEEP  = 4'd7;

    localparam int          PADDR_W = 3;
    localparam logic        REG_SOUND_ENABLE = 1'b0;
    localparam logic        REG_VOLUME_LEVEL = 1'b1;

    // Sweep frequency for stages 0..7: 1000 - 25*stage.
    function automatic logic [15:0] sweep_freq(input logic [2:0] stage);
        logic [15:0] step;
        step = FREQ_STEP * {13'd0, stage};
        return FREQ_BASE - step;
    endfunction

endpackage

`default_nettype wire

/* design/beeper_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// beeper_pattern_sequencer
// Buzzer pattern controller driven by millisecond ticks, start requests and
// frequency writes; one status beat out for every beat in.
// ----------------------------------------------------------------------------
// Each input beat (a tick, a tone start or a frequency write) updates the
// pattern state in the cycle it is accepted and yields exactly one output beat
// carrying the state after that update. A beat can be taken every clock
// cycle while s_tready is high; each result is registered. The output side is a
// result register backed by one skid register, so the input keeps accepting
// while one result waits, and s_tready drops only when both are full.
// Configuration: sound_enable at byte address 0, volume_level at address 4.
`default_nettype none

module beeper_pattern_sequencer
    import bps_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // APB configuration port
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [31:0]        pwdata,
    output logic      [31:0]        prdata,
    output logic                    pready,
    // input stream
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire logic [23:0]        s_tdata,  // [7:0] tone_code, [23:8] freq_value
    input  wire logic [1:0]         s_tuser,  // [1:0] mode
    // output stream
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic      [23:0]        m_tdata   // [0] beeper_on, [16:1] tone_freq,
                                              // [17] busy_res, [19:18] volume_out,
                                              // [23:20] zero
);

    logic        sound_enable_reg;
    logic [1:0]  volume_level_reg;

    logic [7:0]  active_tone_reg,  active_tone_next;
    logic [3:0]  stage_reg,        stage_next;
    logic [7:0]  countdown_reg,    countdown_next;
    logic        first_step_reg,   first_step_next;
    logic        gen_running_reg,  gen_running_next;
    logic [15:0] freq_reg,         freq_next;

    logic        out_valid_reg,  out_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    logic [19:0] out_data_reg,   out_data_next;
    logic [19:0] skid_data_reg,  skid_data_next;

    logic        in_accept;
    logic        out_take;
    logic        cfg_write;
    mode_t       in_mode;
    logic [7:0]  in_tone;
    logic [15:0] in_freq;
    logic [7:0]  cd_dec;
    logic [19:0] result;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        prdata = 32'd0;
        case (paddr[2])
            REG_SOUND_ENABLE: prdata = {31'd0, sound_enable_reg};
            REG_VOLUME_LEVEL: prdata = {30'd0, volume_level_reg};
            default:          prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sound_enable_reg <= 1'b0;
            volume_level_reg <= 2'd0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                REG_SOUND_ENABLE: sound_enable_reg <= pwdata[0];
                REG_VOLUME_LEVEL: volume_level_reg <= pwdata[1:0];
                default:          ;
            endcase
        end
    end

    assign s_tready  = !skid_valid_reg;
    assign in_accept = s_tvalid && s_tready;
    assign out_take  = out_valid_reg && m_tready;
    assign in_mode   = mode_t'(s_tuser);
    assign in_tone   = s_tdata[7:0];
    assign in_freq   = s_tdata[23:8];
    assign cd_dec    = countdown_reg - 8'd1;

    // pattern state update
    always_comb
    begin
        logic       run;
        logic [3:0] st;
        active_tone_next = active_tone_reg;
        stage_next       = stage_reg;
        countdown_next   = countdown_reg;
        first_step_next  = first_step_reg;
        gen_running_next = gen_running_reg;
        freq_next        = freq_reg;
        run              = 1'b0;
        st               = stage_reg;

        if (in_accept)
        begin
            case (in_mode)
                MODE_TICK:
                begin
                    if (sound_enable_reg && active_tone_reg != TONE_NONE)
                    begin
                        if (first_step_reg)
                        begin
                            first_step_next = 1'b0;
                            st  = 4'd0;
                            run = 1'b1;
                        end
                        else
                        begin
                            countdown_next = cd_dec;
                            run = (cd_dec == 8'd0);
                        end
                    end
                end
                MODE_START:    active_tone_next = in_tone;
                MODE_SET_FREQ: freq_next = in_freq;
                default:       ;
            endcase
        end

        if (run)
        begin
            stage_next = st + 4'd1;
            case (active_tone_reg)
                TONE_SHORT:
                begin
                    gen_running_next = 1'b1;
                    countdown_next   = LEN_SHORT;
                    if (st != 4'd0)
                        active_tone_next = TONE_NONE;
                end
                TONE_DOUBLE:
                begin
                    gen_running_next = !st[0];
                    countdown_next   = LEN_LONG;
                    if (st > LAST_STAGE_DOUBLE)
                        active_tone_next = TONE_NONE;
                end
                TONE_TRIPLE:
                begin
                    gen_running_next = !st[0];
                    countdown_next   = LEN_LONG;
                    if (st > LAST_STAGE_TRIPLE)
                        active_tone_next = TONE_NONE;
                end
                TONE_SWEEP:
                begin
                    gen_running_next = 1'b1;
                    countdown_next   = LEN_SWEEP;
                    if (st > LAST_STAGE_SWEEP)
                    begin
                        freq_next        = FREQ_BASE;
                        active_tone_next = TONE_NONE;
                    end
                    else
                        freq_next = sweep_freq(st[2:0]);
                end
                default: active_tone_next = TONE_NONE;
            endcase

            // pattern finished: countdown keeps its decremented value, or its old value on a first step
            if (active_tone_next == TONE_NONE)
            begin
                gen_running_next = 1'b0;
                stage_next       = 4'd0;
                first_step_next  = 1'b1;
                if (!first_step_reg)
                    countdown_next = cd_dec;
                else
                    countdown_next = countdown_reg;
            end
        end
    end

    assign result = {volume_level_reg, (active_tone_next != TONE_NONE),
                     freq_next, gen_running_next};

    // result register plus skid register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (in_accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_valid_next = 1'b1;
                out_data_next  = result;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = result;
            end
        end
        else if (out_take)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
                out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_tone_reg <= TONE_SHORT;
            stage_reg       <= 4'd0;
            countdown_reg   <= 8'd1;
            first_step_reg  <= 1'b1;
            gen_running_reg <= 1'b0;
            freq_reg        <= FREQ_BASE;
            out_valid_reg   <= 1'b0;
            skid_valid_reg  <= 1'b0;
        end
        else
        begin
            active_tone_reg <= active_tone_next;
            stage_reg       <= stage_next;
            countdown_reg   <= countdown_next;
            first_step_reg  <= first_step_next;
            gen_running_reg <= gen_running_next;
            freq_reg        <= freq_next;
            out_valid_reg   <= out_valid_next;
            skid_valid_reg  <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_data_reg};

`ifndef ASSERT_OFF
    // skid register only fills behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register full while result register empty");

    // a beat accepted against a stalled output lands in the skid register
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && out_valid_reg && !m_tready) |=> skid_valid_reg)
        else $error("beat accepted under stall was not held");

    // a tick while idle leaves the pattern untouched
    a_idle_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_mode == MODE_TICK && active_tone_reg == TONE_NONE)
        |=> ($stable(stage_reg) && $stable(countdown_reg) && $stable(gen_running_reg)))
        else $error("tick with no active tone changed the pattern");
`endif

endmodule

`default_nettype wire

/* test/tb_beeper_pattern_sequencer.sv */
// ----------------------------------------------------------------------------
// tb_beeper_pattern_sequencer
// Self-checking bench for the beeper pattern sequencer.
// ----------------------------------------------------------------------------
// Streams ticks, tone starts and frequency writes into the block. A behavioural
// model of the tone patterns predicts the status beat for every input beat, and
// each output beat is compared against it, field by field. Both stream sides
// stall at random, and the output side holds off once for a long stretch so
// that the block fills up and stalls its input. Registers are rewritten between
// phases while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bps_pkg::*;

typedef struct packed {
    logic [1:0]  volume;
    logic        busy;
    logic [15:0] freq;
    logic        beeper;
} beep_status_t;

class beep_scoreboard;
    localparam logic [7:0]  BEEP_TICKS  = 8'd30;
    localparam logic [7:0]  PULSE_TICKS = 8'd50;
    localparam logic [7:0]  SWEEP_TICKS = 8'd40;
    localparam logic [15:0] BASE_HZ     = 16'd1000;

    bit          enable;
    logic [1:0]  volume;
    logic [7:0]  tone;
    logic [3:0]  stage;
    logic [7:0]  countdown;
    bit          first;
    bit          running;
    logic [15:0] freq;

    beep_status_t status_q[$];
    int errors;

    function new();
        enable    = 1'b0;
        volume    = 2'd0;
        tone      = TONE_SHORT;
        stage     = 4'd0;
        countdown = 8'd1;
        first     = 1'b1;
        running   = 1'b0;
        freq      = BASE_HZ;
        errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
        if (idx == REG_SOUND_ENABLE)
            enable = value[0];
        else
            volume = value[1:0];
    endfunction

    function int pending();
        return status_q.size();
    endfunction

    // Apply one accepted input beat and queue the resulting status.
    function void note_beat(mode_t m, logic [7:0] tone_code, logic [15:0] freq_value);
        bit expired;
        bit done;
        beep_status_t s;
        case (m)
            MODE_TICK:
                if (enable && tone != TONE_NONE)
                begin
                    expired = 1'b1;
                    if (first)
                    begin
                        first = 1'b0;
                        stage = 4'd0;
                    end
                    else
                    begin
                        countdown = countdown - 8'd1;
                        expired = (countdown == 8'd0);
                    end
                    if (expired)
                    begin
                        done = 1'b0;
                        case (tone)
                            TONE_SHORT:
                                if (stage != 4'd0)
                                    done = 1'b1;
                                else
                                begin
                                    running = 1'b1;
                                    countdown = BEEP_TICKS;
                                end
                            TONE_DOUBLE:
                                if (stage > 4'd3)
                                    done = 1'b1;
                                else
                                begin
                                    running = !stage[0];
                                    countdown = PULSE_TICKS;
                                end
                            TONE_TRIPLE:
                                if (stage > 4'd4)
                                    done = 1'b1;
                                else
                                begin
                                    running = !stage[0];
                                    countdown = PULSE_TICKS;
                                end
                            TONE_SWEEP:
                            begin
                                running = 1'b1;
                                if (stage > 4'd7)
                                begin
                                    freq = BASE_HZ;
                                    done = 1'b1;
                                end
                                else
                                begin
                                    freq = BASE_HZ - 16'd25 * {12'd0, stage};
                                    countdown = SWEEP_TICKS;
                                end
                            end
                            default:
                                done = 1'b1;
                        endcase
                        if (done)
                        begin
                            running = 1'b0;
                            stage   = 4'd0;
                            tone    = TONE_NONE;
                            first   = 1'b1;
                        end
                        else
                            stage = stage + 4'd1;
                    end
                end
            MODE_START:    tone = tone_code;
            MODE_SET_FREQ: freq = freq_value;
            default:       ;
        endcase
        s.beeper = running;
        s.freq   = freq;
        s.busy   = (tone != TONE_NONE);
        s.volume = volume;
        status_q.push_back(s);
    endfunction

    function void check_beat(logic [23:0] data);
        beep_status_t want;
        beep_status_t got;
        got = data[19:0];
        if (status_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("unexpected status beat %h", data);
            return;
        end
        want = status_q.pop_front();
        if (got.beeper !== want.beeper || got.freq !== want.freq ||
            got.busy !== want.busy || got.volume !== want.volume)
        begin
            errors++;
            if (errors <= 10)
                $display("status mismatch: on %b/%b freq %0d/%0d busy %b/%b vol %0d/%0d",
                         want.beeper, got.beeper, want.freq, got.freq,
                         want.busy, got.busy, want.volume, got.volume);
        end
    endfunction
endclass

module tb_beeper_pattern_sequencer;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;   // [7:0] tone_code, [23:8] freq_value
    logic [1:0]         s_tuser;   // [1:0] mode
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;   // [0] beeper_on, [16:1] tone_freq, [17] busy_res,
                                   // [19:18] volume_out

    beep_scoreboard status_sb;
    bit             send_quiet;
    int             status_beats;

    beeper_pattern_sequencer uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Mostly back-to-back, sometimes a short gap, now and then a long gap.
    function automatic int pick_gap(bit quiet);
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    task automatic send_beat(mode_t m, logic [7:0] tone_code, logic [15:0] freq_value);
        int gap;
        gap = pick_gap(send_quiet);
        repeat (gap)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= m;
        s_tdata  <= {freq_value, tone_code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        status_sb.note_beat(m, tone_code, freq_value);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (status_sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        status_sb.write_reg(idx, value);
    endtask

    task automatic set_config(bit en, logic [1:0] vol);
        wait_idle();
        write_reg(REG_SOUND_ENABLE, {31'd0, en});
        write_reg(REG_VOLUME_LEVEL, {30'd0, vol});
    endtask

    // Ticks needed to run a pattern from its first stage through to its end.
    function automatic int pattern_ticks(logic [7:0] t);
        case (t)
            TONE_SHORT:  return 31;
            TONE_DOUBLE: return 201;
            TONE_TRIPLE: return 251;
            TONE_SWEEP:  return 321;
            default:     return 2;
        endcase
    endfunction

    task automatic run_phase(int budget, logic [7:0] lead_tone);
        int sent;
        int n;
        int r;
        logic [7:0] t;
        sent = 0;
        t = lead_tone;
        while (sent < budget)
        begin
            send_quiet = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            if (r < 8)
            begin
                send_beat(MODE_START, t, 16'($urandom));
                n = pattern_ticks(t);
                if ($urandom_range(0, 9) < 3)
                    n = $urandom_range(1, n);
                else
                    n = n + $urandom_range(0, 4);
                // keep the phase within its budget
                if (n > budget - sent - 1)
                    n = budget - sent - 1;
                sent += n + 1;
                repeat (n)
                begin
                    r = $urandom_range(0, 99);
                    if (r == 0)
                        send_beat(MODE_SET_FREQ, 8'($urandom), 16'($urandom));
                    else if (r == 1)
                        send_beat(MODE_START, 8'($urandom), 16'($urandom));
                    else if (r == 2)
                        send_beat(MODE_UNUSED, 8'($urandom), 16'($urandom));
                    else
                        send_beat(MODE_TICK, 8'($urandom), 16'($urandom));
                end
            end
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    send_beat(mode_t'($urandom_range(0, 3)), 8'($urandom),
                              16'($urandom));
                    sent++;
                end
            end
            // next pattern: mostly a real tone, sometimes none or a bad code
            r = $urandom_range(0, 19);
            if (r == 0)
                t = TONE_NONE;
            else if (r < 3)
                t = 8'($urandom_range(5, 255));
            else
                t = 8'($urandom_range(1, 4));
        end
    endtask

    // Output side: random stalls, plus one long hold-off to back the block up.
    initial
    begin
        int  stall;
        bit  held;
        bit  quiet;
        m_tready <= 1'b0;
        stall = 0;
        held  = 1'b0;
        quiet = 1'b0;
        status_beats = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else
                m_tready <= 1'b1;
            @(posedge clk);
            if (m_tvalid && m_tready)
            begin
                status_sb.check_beat(m_tdata);
                status_beats++;
                if ($urandom_range(0, 49) == 0)
                    quiet = !quiet;
                stall = pick_gap(quiet);
                if (!held && status_beats >= 300)
                begin
                    held  = 1'b1;
                    stall = 200;
                end
            end
        end
    end

    initial
    begin
        status_sb  = new();
        send_quiet = 1'b0;
        rst_n    <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= MODE_TICK;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // disabled: ticks freeze, unused mode changes nothing
        set_config(1'b0, 2'd3);
        send_beat(MODE_TICK, 8'h00, 16'h0000);
        send_beat(MODE_UNUSED, 8'hFF, 16'hFFFF);
        send_beat(MODE_TICK, 8'hFF, 16'hFFFF);
        send_beat(MODE_SET_FREQ, 8'h00, 16'hFFFF);

        // enabled: the tone left over from reset starts on the first tick
        set_config(1'b1, 2'd0);
        send_beat(MODE_TICK, 8'h00, 16'h0000);
        send_beat(MODE_SET_FREQ, 8'hFF, 16'h0000);
        send_beat(MODE_SET_FREQ, 8'h00, 16'hFFFF);
        send_beat(MODE_START, TONE_NONE, 16'h5555);
        send_beat(MODE_TICK, 8'h00, 16'h0000);
        send_beat(MODE_TICK, 8'h00, 16'h0000);
        send_beat(MODE_START, TONE_SWEEP, 16'hAAAA);
        send_beat(MODE_TICK, 8'h00, 16'h0000);
        send_beat(MODE_START, 8'hAA, 16'h0000);
        send_beat(MODE_TICK, 8'h55, 16'h0000);
        send_beat(MODE_START, 8'h55, 16'h0000);
        send_beat(MODE_TICK, 8'hFF, 16'h0000);
        send_beat(MODE_START, TONE_DOUBLE, 16'h0000);
        send_beat(MODE_SET_FREQ, 8'h00, 16'd1000);
        send_beat(MODE_UNUSED, 8'h00, 16'h0000);

        set_config(1'b1, 2'd1);
        run_phase(340, TONE_SWEEP);
        set_config(1'b0, 2'd2);
        run_phase(300, TONE_TRIPLE);
        set_config(1'b1, 2'd3);
        run_phase(340, TONE_TRIPLE);
        set_config(1'b1, 2'd0);
        run_phase(340, TONE_DOUBLE);

        wait_idle();
        repeat (10) @(posedge clk);
        if (status_sb.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

/* sim.f */
design/bps_pkg.sv
design/beeper_pattern_sequencer.sv
test/tb_beeper_pattern_sequencer.sv
